// ===== sv/nsmc_pkg.sv =====
// Shared constants and opcodes for the neighbor swap Monte Carlo step block.
`timescale 1ns / 1ps

package nsmc_pkg;

    // Default number of target positions
    localparam int POSITIONS_DEFAULT = 128;

    // Field widths
    localparam int CELL_W   = 7;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 16;
    localparam int DRAW_W   = 16;
    localparam int GAIN_W   = 28;
    localparam int OP_W     = 2;

    // Arithmetic widths: differences, product, gain times product magnitude
    localparam int DIFF_W   = VALUE_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int MAG_W    = 2 * VALUE_W;
    localparam int TERM_W   = GAIN_W + MAG_W;
    localparam int CMP_W    = TERM_W + 2;
    localparam int FRAC_SH  = 20;
    localparam int HALF_SH  = 35;

    // Gain after reset: 30.0 in Q20.8
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(7680);

    // Item opcodes
    localparam logic [OP_W-1:0] OP_EXCHANGE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_CELL   = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_LIGAND = 2'd2;
    localparam logic [OP_W-1:0] OP_WR_RECEPT = 2'd3;

endpackage

// ===== sv/neighbour_swap_monte_carlo_step.sv =====
// Top level: neighbor swap Monte Carlo step over a cell mapping and two expression tables.
`timescale 1ns / 1ps

// Sequence: a write word goes from accept straight to the done state; an exchange steps
//   through RD1, RD2, MUL, CMP and, when it swaps, WB1 and WB2 (two mapping write-backs
//   through the single RAM write port). One word at a time: the next word is taken once
//   the result enters the output register.
// Reset: the mapping reads as the identity through per-entry valid flops; the gain
//   returns to 30.0; the tables hold nothing defined until loaded.

module neighbour_swap_monte_carlo_step #(
    parameter int POSITIONS = nsmc_pkg::POSITIONS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [nsmc_pkg::OP_W-1:0]     opcode,
    input  logic [nsmc_pkg::POS_W-1:0]    position,
    input  logic [nsmc_pkg::VALUE_W-1:0]  entry_value,
    input  logic [nsmc_pkg::DRAW_W-1:0]   random_draw,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          swapped,
    output logic [nsmc_pkg::CELL_W-1:0]   left_cell,
    output logic [nsmc_pkg::CELL_W-1:0]   right_cell,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nsmc_pkg::GAIN_W-1:0]   exchange_gain
);

    // Only positions reachable by the index field need storage
    localparam int REACH = 1 << nsmc_pkg::POS_W;
    localparam int DEPTH = (POSITIONS < REACH) ? POSITIONS : REACH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = nsmc_pkg::CELL_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD1  = 3'd1;
    localparam logic [2:0] ST_RD2  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_WB1  = 3'd5;
    localparam logic [2:0] ST_WB2  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]                          state_reg, state_next;
    logic [DEPTH-1:0]                    cell_valid_reg, cell_valid_next;
    logic [nsmc_pkg::GAIN_W-1:0]         gain_reg;
    logic                                result_valid_reg, result_valid_next;

    logic [nsmc_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [nsmc_pkg::DRAW_W-1:0]         draw_reg, draw_next;
    logic [CW-1:0]                       a_reg, a_next;
    logic [CW-1:0]                       b_reg, b_next;
    logic signed [nsmc_pkg::DIFF_W-1:0]  ldiff_reg, ldiff_next;
    logic signed [nsmc_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [nsmc_pkg::TERM_W-1:0]         term_reg, term_next;
    logic                                neg_reg, neg_next;
    logic                                swap_reg, swap_next;
    logic [CW-1:0]                       left_reg, left_next;
    logic [CW-1:0]                       right_reg, right_next;
    logic                                swapped_reg, swapped_out_next;
    logic [CW-1:0]                       left_out_reg, left_out_next;
    logic [CW-1:0]                       right_out_reg, right_out_next;

    logic                                accept;
    logic                                in_range;
    logic                                pair_ok;
    logic                                out_free;
    logic [AW-1:0]                       addr_i;
    logic [AW-1:0]                       addr_i1;
    logic [AW-1:0]                       pos_addr;
    logic [AW-1:0]                       pos_addr1;

    logic                                cell_we;
    logic [AW-1:0]                       cell_waddr;
    logic [CW-1:0]                       cell_wdata;
    logic [CW-1:0]                       cell_q_a, cell_q_b;
    logic [nsmc_pkg::VALUE_W-1:0]        lig_q_a, lig_q_b;
    logic [nsmc_pkg::VALUE_W-1:0]        rec_q_a, rec_q_b;
    logic                                lig_we, rec_we;
    logic [CW-1:0]                       a_cur, b_cur;
    logic [AW-1:0]                       mod_tab [REACH];

    logic signed [nsmc_pkg::DIFF_W-1:0]  rdiff;
    logic signed [nsmc_pkg::PROD_W-1:0]  prod_abs;
    logic [nsmc_pkg::MAG_W-1:0]          mag;
    logic [nsmc_pkg::CMP_W-1:0]          draw_q36;
    logic [nsmc_pkg::CMP_W-1:0]          cmp_lhs, cmp_rhs;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_free   = !result_valid_reg || !result_stall;
    assign in_range   = (32'(position) < POSITIONS);
    assign pair_ok    = (32'(position) + 32'd1 < POSITIONS);
    assign addr_i     = position[AW-1:0];
    assign addr_i1    = position[AW-1:0] + AW'(1);
    assign pos_addr   = pos_reg[AW-1:0];
    assign pos_addr1  = pos_reg[AW-1:0] + AW'(1);

    // Cell index reduced modulo the number of positions, as a constant table
    for (genvar k = 0; k < REACH; k++)
    begin : g_mod
        assign mod_tab[k] = AW'(k % POSITIONS);
    end

    // Unwritten mapping entries read as their own index
    assign a_cur = cell_valid_reg[pos_addr]  ? cell_q_a : pos_reg;
    assign b_cur = cell_valid_reg[pos_addr1] ? cell_q_b : CW'(pos_reg + CW'(1));

    // Mapping write port: load words at accept, swap write-back afterwards
    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = addr_i;
        cell_wdata = entry_value[CW-1:0];
        if (state_reg == ST_WB1)
        begin
            cell_we    = 1'b1;
            cell_waddr = pos_addr;
            cell_wdata = b_reg;
        end
        else if (state_reg == ST_WB2)
        begin
            cell_we    = 1'b1;
            cell_waddr = pos_addr1;
            cell_wdata = a_reg;
        end
        else if (accept && (opcode == nsmc_pkg::OP_WR_CELL) && in_range)
        begin
            cell_we = 1'b1;
        end
    end

    assign lig_we = accept && (opcode == nsmc_pkg::OP_WR_LIGAND) && in_range;
    assign rec_we = accept && (opcode == nsmc_pkg::OP_WR_RECEPT) && in_range;

    nsmc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cell_ram (
        .clk     (clk),
        .we      (cell_we),
        .waddr   (cell_waddr),
        .wdata   (cell_wdata),
        .raddr_a (addr_i),
        .raddr_b (addr_i1),
        .rdata_a (cell_q_a),
        .rdata_b (cell_q_b)
    );

    nsmc_ram #(.WIDTH(nsmc_pkg::VALUE_W), .DEPTH(DEPTH)) u_ligand_ram (
        .clk     (clk),
        .we      (lig_we),
        .waddr   (addr_i),
        .wdata   (entry_value),
        .raddr_a (addr_i),
        .raddr_b (addr_i1),
        .rdata_a (lig_q_a),
        .rdata_b (lig_q_b)
    );

    nsmc_ram #(.WIDTH(nsmc_pkg::VALUE_W), .DEPTH(DEPTH)) u_receptor_ram (
        .clk     (clk),
        .we      (rec_we),
        .waddr   (addr_i),
        .wdata   (entry_value),
        .raddr_a (mod_tab[a_cur]),
        .raddr_b (mod_tab[b_cur]),
        .rdata_a (rec_q_a),
        .rdata_b (rec_q_b)
    );

    // Datapath arithmetic
    assign rdiff    = $signed({1'b0, rec_q_a}) - $signed({1'b0, rec_q_b});
    assign prod_abs = prod_reg[nsmc_pkg::PROD_W-1] ? -prod_reg : prod_reg;
    assign mag      = prod_abs[nsmc_pkg::MAG_W-1:0];
    assign draw_q36 = nsmc_pkg::CMP_W'({draw_reg, nsmc_pkg::FRAC_SH'(0)});

    // Compare draw against one half plus or minus the gain term
    always_comb
    begin
        if (neg_reg)
        begin
            cmp_lhs = draw_q36 + nsmc_pkg::CMP_W'(term_reg);
            cmp_rhs = nsmc_pkg::CMP_W'(1) << nsmc_pkg::HALF_SH;
        end
        else
        begin
            cmp_lhs = draw_q36;
            cmp_rhs = (nsmc_pkg::CMP_W'(1) << nsmc_pkg::HALF_SH) + nsmc_pkg::CMP_W'(term_reg);
        end
    end

    // Sequencer and next values
    always_comb
    begin
        state_next        = state_reg;
        cell_valid_next   = cell_valid_reg;
        result_valid_next = result_valid_reg;
        pos_next          = pos_reg;
        draw_next         = draw_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        ldiff_next        = ldiff_reg;
        prod_next         = prod_reg;
        term_next         = term_reg;
        neg_next          = neg_reg;
        swap_next         = swap_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        swapped_out_next  = swapped_reg;
        left_out_next     = left_out_reg;
        right_out_next    = right_out_reg;

        // Drop the result once taken
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (cell_we)
        begin
            cell_valid_next[cell_waddr] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next   = position;
                    draw_next  = random_draw;
                    swap_next  = 1'b0;
                    left_next  = '0;
                    right_next = '0;
                    if ((opcode == nsmc_pkg::OP_EXCHANGE) && pair_ok)
                    begin
                        state_next = ST_RD1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RD1:
            begin
                a_next     = a_cur;
                b_next     = b_cur;
                ldiff_next = $signed({1'b0, lig_q_a}) - $signed({1'b0, lig_q_b});
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                prod_next  = rdiff * ldiff_reg;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                neg_next   = prod_reg[nsmc_pkg::PROD_W-1];
                term_next  = nsmc_pkg::TERM_W'(gain_reg) * nsmc_pkg::TERM_W'(mag);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                swap_next  = (cmp_lhs < cmp_rhs);
                left_next  = (cmp_lhs < cmp_rhs) ? b_reg : a_reg;
                right_next = (cmp_lhs < cmp_rhs) ? a_reg : b_reg;
                state_next = (cmp_lhs < cmp_rhs) ? ST_WB1 : ST_DONE;
            end
            ST_WB1:
            begin
                state_next = ST_WB2;
            end
            ST_WB2:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand the result to the output register when it frees up
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    swapped_out_next  = swap_reg;
                    left_out_next     = left_reg;
                    right_out_next    = right_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cell_valid_reg   <= '0;
            result_valid_reg <= 1'b0;
            gain_reg         <= nsmc_pkg::GAIN_RESET;
            swap_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cell_valid_reg   <= cell_valid_next;
            result_valid_reg <= result_valid_next;
            swap_reg         <= swap_next;
            if (cfg_valid && cfg_ready)
            begin
                gain_reg <= exchange_gain;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        draw_reg      <= draw_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        ldiff_reg     <= ldiff_next;
        prod_reg      <= prod_next;
        term_reg      <= term_next;
        neg_reg       <= neg_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        swapped_reg   <= swapped_out_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign result_valid = result_valid_reg;
    assign swapped      = swapped_reg;
    assign left_cell    = left_out_reg;
    assign right_cell   = right_out_reg;

    // Mapping writes happen only on a load word or in the write-back states
    a_cell_we_source: assert property (@(posedge clk) disable iff (!rst_n)
        cell_we |-> (accept || (state_reg == ST_WB1) || (state_reg == ST_WB2)))
        else $error("mapping written outside load or write-back");

    // Write-back runs only for a decided swap
    a_wb_needs_swap: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WB1) || (state_reg == ST_WB2)) |-> swap_reg)
        else $error("write-back without swap");

    // Both halves of the swap are written in consecutive cycles
    a_wb_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB1) |=> (state_reg == ST_WB2))
        else $error("swap write-back split");

    // A new result is loaded only from the done state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside done state");

endmodule

// ===== sv/nsmc_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
`timescale 1ns / 1ps

module nsmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read two
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
